/* rtl/smf_pkg.sv */
// Shared constants and types of the sliding median filter.
`default_nettype none

package smf_pkg;

    localparam int SMF_SAMPLE_W   = 32;
    localparam int SMF_CFG_W      = 4;
    localparam int SMF_MAX_WINDOW = 15;
    localparam logic [SMF_CFG_W-1:0] SMF_WINDOW_RESET = 4'd5;

    // Per-cycle commands broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;   // take a new item: shift the history, reload probe, clear rank
        logic run;     // one ranking step: compare probe, advance probe chain
    } t_cell_ctrl;

endpackage

`default_nettype wire

/* rtl/smf_if.sv */
// Valid/ready channel interfaces for samples in and medians out.
`default_nettype none

interface smf_sample_if import smf_pkg::*;;
    logic                           valid;
    logic                           ready;
    logic signed [SMF_SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface smf_median_if import smf_pkg::*;;
    logic                           valid;
    logic                           ready;
    logic signed [SMF_SAMPLE_W-1:0] median_value;

    modport source (output valid, output median_value, input ready);
    modport sink   (input valid, input median_value, output ready);
endinterface

`default_nettype wire

/* rtl/smf_cell.sv */
// One cell of the ranking chain: a history slot, a travelling probe and a rank counter.
`default_nettype none

module smf_cell import smf_pkg::*; #(
    parameter int IDX   = 0,
    parameter int CNT_W = 4
) (
    input  wire logic                           i_clk,
    input  wire t_cell_ctrl                     i_ctrl,
    input  wire logic signed [SMF_SAMPLE_W-1:0] i_prev_sample,
    input  wire logic signed [SMF_SAMPLE_W-1:0] i_next_probe,
    input  wire logic [CNT_W-1:0]               i_step,
    input  wire logic [CNT_W-1:0]               i_window,
    input  wire logic [CNT_W-1:0]               i_med_idx,
    output logic signed [SMF_SAMPLE_W-1:0]      o_sample,
    output logic signed [SMF_SAMPLE_W-1:0]      o_probe,
    output logic                                o_hit
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic signed [SMF_SAMPLE_W-1:0] r_sample;
    logic signed [SMF_SAMPLE_W-1:0] r_probe;
    logic [CNT_W-1:0]               r_rank;
    logic                           in_window;
    logic [CNT_W:0]                 probe_pos;
    logic                           wrapped;
    logic                           below;

    assign in_window = MY_IDX < i_window;
    // The probe seen at step k started in slot (IDX + k) mod W; once that sum
    // reaches W it has wrapped round and came from a newer slot than this one.
    assign probe_pos = {1'b0, MY_IDX} + {1'b0, i_step};
    assign wrapped   = probe_pos >= {1'b0, i_window};
    // Ties are broken by position so that equal values get distinct ranks.
    assign below = (r_probe < r_sample) || ((r_probe == r_sample) && wrapped);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_sample <= i_prev_sample;
            r_probe  <= i_prev_sample;
            r_rank   <= '0;
        end else if (i_ctrl.run) begin
            r_probe <= i_next_probe;
            if (in_window && below) begin
                r_rank <= r_rank + 1'b1;
            end
        end
    end

    assign o_sample = r_sample;
    assign o_probe  = r_probe;
    assign o_hit    = in_window && (r_rank == i_med_idx);

endmodule

`default_nettype wire

/* rtl/sliding_median_filter_unit.sv */
// Top level of the sliding median filter: history chain, sequencer and output register.
//
//  channel       | dir | handshake          | payload
//  --------------+-----+--------------------+--------------------------------
//  i_sample_ch   | in  | valid / ready      | sample, signed Q16.16
//  o_median_ch   | out | valid / ready      | median_value, signed Q16.16
//  i_cfg_*       | in  | write enable only  | window_length, 4 bits
//
//  An item that completes no window is done once it is accepted. An item that
//  yields a median passes the accept step, W ranking steps in which the probe
//  chain walks every windowed sample past every cell, and a select step.
//  Reset (synchronous, active low) clears the history fill level and sets the window to 5.
//  A finished median waits in the output register; the next item is taken
//  meanwhile, and only its own select step holds while that register is full and not taken.
`default_nettype none

module sliding_median_filter_unit import smf_pkg::*; #(
    parameter int MAX_WINDOW = SMF_MAX_WINDOW
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [SMF_CFG_W-1:0] i_cfg_data,
    smf_sample_if.sink                i_sample_ch,
    smf_median_if.source              o_median_ch
);

    // Count width: must hold MAX_WINDOW itself (fill level saturates there).
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int CMP_W = (CNT_W > SMF_CFG_W) ? CNT_W : SMF_CFG_W;
    // Largest odd window that fits the history.
    localparam int CAP   = ((MAX_WINDOW % 2) == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_SEL
    } t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_k;
    logic [CNT_W-1:0]               r_fill;
    logic [SMF_CFG_W-1:0]           r_cfg;
    logic                           r_out_valid;
    logic signed [SMF_SAMPLE_W-1:0] r_out_data;

    logic                           accept;
    logic                           out_load;
    logic [CNT_W-1:0]               n_fill;
    logic [CMP_W-1:0]               w_req;
    logic [CMP_W-1:0]               w_cap;
    logic [CNT_W-1:0]               w_eff;
    logic [CNT_W-1:0]               med_idx;
    t_cell_ctrl                     ctrl;
    logic signed [SMF_SAMPLE_W-1:0] median_sel;

    logic signed [SMF_SAMPLE_W-1:0] cell_sample [MAX_WINDOW];
    logic signed [SMF_SAMPLE_W-1:0] cell_probe  [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]          cell_hit;

    assign accept = i_sample_ch.valid && i_sample_ch.ready;

    // Force the window odd, then clip it to the history depth.
    assign w_req   = CMP_W'({r_cfg[SMF_CFG_W-1:1], 1'b1});
    assign w_cap   = (w_req > CMP_W'(CAP)) ? CMP_W'(CAP) : w_req;
    assign w_eff   = w_cap[CNT_W-1:0];
    assign med_idx = w_eff >> 1;

    // Saturate the fill level at the history depth.
    assign n_fill = (r_fill == CNT_W'(MAX_WINDOW)) ? r_fill : r_fill + 1'b1;

    assign ctrl.shift = accept;
    assign ctrl.run   = (r_state == ST_RUN);

    // Load the output register from the select step once it is free or being emptied.
    assign out_load = (r_state == ST_SEL) && (!r_out_valid || o_median_ch.ready);

    // Probes circulate round the first W cells: the last windowed cell takes
    // its next probe from cell 0, so every cell meets every windowed sample.
    generate
        for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            logic signed [SMF_SAMPLE_W-1:0] prev_sample;
            logic signed [SMF_SAMPLE_W-1:0] next_probe;

            if (gi == 0) begin : g_head
                assign prev_sample = i_sample_ch.sample;
            end else begin : g_body
                assign prev_sample = cell_sample[gi-1];
            end

            if (gi == MAX_WINDOW - 1) begin : g_tail
                assign next_probe = cell_probe[0];
            end else begin : g_inner
                assign next_probe = (w_eff == CNT_W'(gi + 1)) ? cell_probe[0]
                                                               : cell_probe[gi+1];
            end

            smf_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctrl        (ctrl),
                .i_prev_sample (prev_sample),
                .i_next_probe  (next_probe),
                .i_step        (r_k),
                .i_window      (w_eff),
                .i_med_idx     (med_idx),
                .o_sample      (cell_sample[gi]),
                .o_probe       (cell_probe[gi]),
                .o_hit         (cell_hit[gi])
            );
        end
    endgenerate

    // Exactly one windowed cell holds the middle rank: pick it with an AND-OR mux.
    always_comb begin
        median_sel = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            median_sel = median_sel | (cell_hit[i] ? cell_sample[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_k         <= '0;
            r_fill      <= '0;
            r_cfg       <= SMF_WINDOW_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            // Load a fresh median, or drop the held one once the sink takes it.
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= median_sel;
            end else if (o_median_ch.valid && o_median_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_fill <= n_fill;
                        r_k    <= '0;
                        if (n_fill >= w_eff) begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (r_k == w_eff - 1'b1) begin
                        r_state <= ST_SEL;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                ST_SEL: begin
                    // Hold until the output register is free or being emptied.
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_sample_ch.ready         = (r_state == ST_IDLE);
    assign o_median_ch.valid         = r_out_valid;
    assign o_median_ch.median_value  = r_out_data;

endmodule

`default_nettype wire

/* rtl/smf_checker.sv */
// Port-level checks of the sliding median filter, bound to the top level.
`default_nettype none

module smf_checker import smf_pkg::*; (
    input wire logic                    i_clk,
    input wire logic                    i_rst_n,
    input wire logic                    i_in_valid,
    input wire logic                    i_in_ready,
    input wire logic                    i_out_valid,
    input wire logic                    i_out_ready,
    input wire logic [SMF_SAMPLE_W-1:0] i_out_data
);

    // A held median keeps its value until taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("median changed or vanished while stalled");

    // A new median appears only from the select step, when no item is taken.
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("median produced while input side was idle");

    // The input side goes busy only because an item was just taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_ready))
        else $error("input stalled without an accepted item");

    // Reset leaves no median pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("median pending after reset");

endmodule

bind sliding_median_filter_unit smf_checker u_smf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample_ch.valid),
    .i_in_ready  (i_sample_ch.ready),
    .i_out_valid (o_median_ch.valid),
    .i_out_ready (o_median_ch.ready),
    .i_out_data  (o_median_ch.median_value)
);

`default_nettype wire

/* dv/tb_sliding_median_filter_unit.sv */
// Self-checking testbench of the sliding median filter: directed and random samples.
`default_nettype none

module tb_sliding_median_filter_unit;
    import smf_pkg::*;

    localparam int    RANDOM_ITEMS = 1750;
    localparam int    SETTLE       = SMF_MAX_WINDOW + 6;  // covers a whole median item
    localparam int    CYCLE_LIMIT  = 500000;
    localparam int    IDLE_PCT     = 28;

    typedef logic signed [SMF_SAMPLE_W-1:0] sample_t;

    localparam sample_t MOST_NEG = {1'b1, {(SMF_SAMPLE_W-1){1'b0}}};
    localparam sample_t MOST_POS = {1'b0, {(SMF_SAMPLE_W-1){1'b1}}};

    // Tracks the window history and holds the medians still owed by the block.
    class median_tracker;
        sample_t         history[SMF_MAX_WINDOW];
        int unsigned     fill_count;
        logic [SMF_CFG_W-1:0] window_length;
        sample_t         medians_due[$];
        int unsigned     mismatches;

        function new();
            fill_count    = 0;
            window_length = SMF_WINDOW_RESET;
            mismatches    = 0;
        endfunction

        function void set_window(logic [SMF_CFG_W-1:0] v);
            window_length = v;
        endfunction

        // Force the window odd and cap it at the largest odd size held.
        function int unsigned active_window();
            int unsigned w;
            int unsigned cap;
            w   = window_length;
            cap = SMF_MAX_WINDOW;
            if (w % 2 == 0) w++;
            if (cap % 2 == 0) cap--;
            if (w > cap) w = cap;
            return w;
        endfunction

        function sample_t window_median(int unsigned w);
            sample_t ordered[SMF_MAX_WINDOW];
            sample_t key;
            int      i;
            int      j;
            for (i = 0; i < w; i++) begin
                key = history[i];
                j   = i;
                while (j > 0 && key < ordered[j-1]) begin
                    ordered[j] = ordered[j-1];
                    j--;
                end
                ordered[j] = key;
            end
            return ordered[w/2];
        endfunction

        function void take_sample(sample_t s);
            int          i;
            int unsigned w;
            for (i = SMF_MAX_WINDOW - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = s;
            if (fill_count < SMF_MAX_WINDOW) fill_count++;
            w = active_window();
            if (fill_count >= w) medians_due = {medians_due, window_median(w)};
        endfunction

        function void check_median(sample_t got);
            sample_t want;
            if (medians_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected median %0d (0x%08h)", got, got);
            end else begin
                want = medians_due[0];
                medians_due.delete(0);
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("median mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                                 want, want, got, got);
                end
            end
        endfunction

        function int unsigned pending();
            return medians_due.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [SMF_CFG_W-1:0] i_cfg_data;

    smf_sample_if sample_ch ();
    smf_median_if median_ch ();

    sliding_median_filter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_sample_ch (sample_ch),
        .o_median_ch (median_ch)
    );

    median_tracker tracker;
    bit            no_idle;
    int unsigned   cycle_count = 0;
    sample_t       value_pool[4];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Drop the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Stall the median channel at random, except in the no-idle stretch.
    always @(posedge i_clk) begin
        median_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Observe every handshake and register write at the clock edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) tracker.set_window(i_cfg_data);
            if (sample_ch.valid && sample_ch.ready) tracker.take_sample(sample_ch.sample);
            if (median_ch.valid && median_ch.ready) tracker.check_median(median_ch.median_value);
        end
    end

    task automatic send_sample(input sample_t v);
        if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.sample <= v;
        do @(posedge i_clk); while (!(sample_ch.valid && sample_ch.ready));
    endtask

    // Wait until every median has arrived and the chain has gone quiet.
    task automatic settle();
        sample_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [SMF_CFG_W-1:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic sample_t next_sample();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick < 5)
            return sample_t'($urandom);
        else if (pick < 7)
            return value_pool[$urandom_range(3)];
        else if (pick < 8) begin
            case ($urandom_range(3))
                0: return MOST_NEG;
                1: return MOST_POS;
                2: return '0;
                default: return '1;
            endcase
        end else
            return sample_t'(($signed($urandom_range(200)) - 100) * 65536);
    endfunction

    initial begin
        int unsigned sent;
        int unsigned phase;
        int unsigned phase_len;
        int unsigned k;
        logic [SMF_CFG_W-1:0] setting;

        tracker          = new();
        no_idle          = 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_data       <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.sample <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset window of five: extremes of the field and duplicates.
        send_sample(MOST_NEG);
        send_sample(MOST_POS);
        send_sample('0);
        send_sample('1);
        send_sample(MOST_NEG);
        send_sample(MOST_POS);
        send_sample(MOST_POS);

        // Zero setting rounds up to one: each sample is its own median.
        write_window(4'd0);
        send_sample(32'sd65536);
        send_sample(MOST_NEG);
        send_sample(MOST_POS);

        // Even setting at the top rounds up to the full fifteen; history is kept.
        write_window(4'd14);
        send_sample(32'sh7FFF_0000);
        send_sample(32'sh8000_FFFF);
        send_sample(32'sh0001_8000);
        send_sample('1);
        send_sample(32'sh5555_AAAA);
        send_sample(32'shAAAA_5555);

        // Shrink while running: the next sample yields at once.
        write_window(4'd2);
        send_sample('0);
        send_sample(MOST_POS);
        send_sample(MOST_NEG);

        // Random phases, each under its own window setting.
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case (phase)
                0: setting = 4'd15;
                1: setting = 4'd1;
                2: setting = 4'd0;
                3: setting = 4'd14;
                default: setting = SMF_CFG_W'($urandom_range(15));
            endcase
            write_window(setting);
            for (k = 0; k < 4; k++) value_pool[k] = sample_t'($urandom);
            phase_len = $urandom_range(40, 160);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                no_idle = (sent >= 800 && sent < 1100);
                send_sample(next_sample());
                sent++;
            end
            phase++;
        end
        no_idle = 1'b0;

        settle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
